// ----- rtl/dda_pkg.sv -----
// shared types and constants for the dda line rasterizer
// command and pixel beat structs, opcode codes, fixed coordinate width
// no dependencies
`timescale 1ns / 1ps

package dda_pkg;

	// coordinate width is fixed by the beat fields
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COLOR_BITS = 8;

	typedef enum logic [1:0] {
		OP_LINE   = 2'd0,
		OP_MOVETO = 2'd1,
		OP_LINETO = 2'd2,
		OP_STEP   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [COORD_BITS-1:0]   start_x;
		logic [COORD_BITS-1:0]   start_y;
		logic [COORD_BITS-1:0]   end_x;
		logic [COORD_BITS-1:0]   end_y;
		logic [COLOR_BITS-1:0]   red;
		logic [COLOR_BITS-1:0]   green;
		logic [COLOR_BITS-1:0]   blue;
	} cmd_beat_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]   pixel_x;
		logic [COORD_BITS-1:0]   pixel_y;
		logic [COLOR_BITS-1:0]   pixel_red;
		logic [COLOR_BITS-1:0]   pixel_green;
		logic [COLOR_BITS-1:0]   pixel_blue;
		logic                    last_pixel;
	} pix_beat_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/dda_div.sv -----
// serial restoring divider, one quotient bit per cycle
// used for the slope at segment setup; depends on dda_pkg
`timescale 1ns / 1ps

module dda_div #(
	parameter int DIVIDEND_W = 28,
	parameter int DIVISOR_W  = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dda_pkg::div_req_t      req,
	input  logic [DIVIDEND_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]   divisor,
	output dda_pkg::div_stat_t     stat,
	output logic [DIVIDEND_W-1:0]  quotient
);
	import dda_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// shift dividend bits out and quotient bits in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	// checks
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero count");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// ----- rtl/dda_line_rasterizer.sv -----
// dda line rasterizer with pen position; top level, depends on dda_pkg and dda_div
// step: pixel registered at the output; one beat per cycle while the pixel output is not stalled
// line and lineto: commands are held off while the serial slope divider runs; moveto, step
//   with no segment and zero-length segments need no division
// reset (arst_n, async, active low) clears pen, the segment active flag and the output valid
`timescale 1ns / 1ps

module dda_line_rasterizer #(
	parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  dda_pkg::cmd_beat_t  cmd,
	output logic                pix_valid,
	input  logic                pix_ready,
	output dda_pkg::pix_beat_t  pix
);
	import dda_pkg::*;

	localparam int ACC_W = COORD_BITS + FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

	state_t                 state_q;
	logic [COORD_BITS-1:0]  pen_x_q, pen_y_q;
	logic                   active_q;
	logic                   major_x_q;
	logic [COORD_BITS-1:0]  major_pos_q, major_stop_q;
	logic [ACC_W-1:0]       accum_q;
	logic [ACC_W:0]         slope_q;
	logic                   neg_q;
	logic [3*COLOR_BITS-1:0] color_q;

	logic                   cmd_fire;
	logic                   is_draw;
	logic                   do_step;
	div_req_t               div_req;
	div_stat_t              div_stat;
	logic [ACC_W-1:0]       quotient;

	// setup signals
	logic [COORD_BITS-1:0]  x0, y0, x1, y1, dx, dy;
	logic [COORD_BITS-1:0]  a0, a1, b0, b1, a_lo, a_hi, b_st, b_en, seg_len, mag;
	logic                   major_x, swap, neg;

	// step signals
	logic [COORD_BITS-1:0]  minor;
	logic [COORD_BITS:0]    next_pos;
	logic                   step_last;

	assign cmd_ready = (state_q == ST_IDLE) && (!pix_valid || pix_ready);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign is_draw   = (cmd.opcode == OP_LINE) || (cmd.opcode == OP_LINETO);
	assign do_step   = cmd_fire && (cmd.opcode == OP_STEP) && active_q;

	// segment setup: major axis, ordering, length and minor delta
	always_comb begin
		x0 = (cmd.opcode == OP_LINETO) ? pen_x_q : cmd.start_x;
		y0 = (cmd.opcode == OP_LINETO) ? pen_y_q : cmd.start_y;
		x1 = cmd.end_x;
		y1 = cmd.end_y;
		dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
		dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
		major_x = dx >= dy;
		a0 = major_x ? x0 : y0;
		a1 = major_x ? x1 : y1;
		b0 = major_x ? y0 : x0;
		b1 = major_x ? y1 : x1;
		swap = a1 < a0;
		a_lo = swap ? a1 : a0;
		a_hi = swap ? a0 : a1;
		b_st = swap ? b1 : b0;
		b_en = swap ? b0 : b1;
		seg_len = a_hi - a_lo;
		neg = b_en < b_st;
		mag = neg ? b_st - b_en : b_en - b_st;
	end

	assign div_req.start = cmd_fire && is_draw && (seg_len != '0);

	dda_div #(
		.DIVIDEND_W (ACC_W),
		.DIVISOR_W  (COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend ({mag, {FRAC_BITS{1'b0}}}),
		.divisor  (seg_len),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// pixel of the current step
	always_comb begin
		minor     = accum_q[ACC_W-1 -: COORD_BITS];
		next_pos  = {1'b0, major_pos_q} + 1'b1;
		step_last = (next_pos[COORD_BITS-1:0] == major_stop_q)
			|| (next_pos >= {1'b0, major_stop_q});
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			active_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.opcode)
							OP_LINE, OP_LINETO: begin
								active_q <= 1'b0;
								if (seg_len != '0)
									state_q <= ST_DIV;
							end
							default: begin
								if (do_step && step_last)
									active_q <= 1'b0;
							end
						endcase
						if ((cmd.opcode == OP_MOVETO) || (cmd.opcode == OP_LINETO)) begin
							pen_x_q <= cmd.end_x;
							pen_y_q <= cmd.end_y;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						active_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// segment datapath
	always_ff @(posedge clk) begin
		if (cmd_fire && is_draw) begin
			major_x_q    <= major_x;
			major_pos_q  <= a_lo;
			major_stop_q <= a_hi;
			accum_q      <= {b_st, {FRAC_BITS{1'b0}}};
			neg_q        <= neg;
			color_q      <= {cmd.red, cmd.green, cmd.blue};
		end else if (do_step) begin
			major_pos_q <= next_pos[COORD_BITS-1:0];
			accum_q     <= accum_q + slope_q[ACC_W-1:0];
		end
		if (div_stat.done)
			slope_q <= neg_q ? (~{1'b0, quotient} + 1'b1) : {1'b0, quotient};
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (do_step) begin
			pix_valid <= 1'b1;
		end else if (pix_ready) begin
			pix_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			pix.pixel_x     <= major_x_q ? major_pos_q : minor;
			pix.pixel_y     <= major_x_q ? minor : major_pos_q;
			pix.pixel_red   <= color_q[3*COLOR_BITS-1 -: COLOR_BITS];
			pix.pixel_green <= color_q[2*COLOR_BITS-1 -: COLOR_BITS];
			pix.pixel_blue  <= color_q[COLOR_BITS-1:0];
			pix.last_pixel  <= step_last;
		end
	end

	// checks
	a_active_order: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> major_pos_q < major_stop_q)
		else $error("active segment past its stop");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && step_last) |=> !active_q)
		else $error("segment still active after last pixel");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("slope ready outside of setup");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !cmd_ready)
		else $error("command taken during slope division");

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for dda_line_rasterizer: directed and random command streams,
// pixel beats checked against a predictor in the scoreboard class below
// depends on dda_pkg and the rtl of dda_line_rasterizer
`timescale 1ns / 1ps

module testbench;
	import dda_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int ACC_W = COORD_BITS + FRAC;
	localparam int MAX_COORD = (1 << COORD_BITS) - 1;
	localparam int RANDOM_ITEMS = 550;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 4000;

	// scoreboard: mirrors pen and segment state, queues the pixels each step must produce
	class pixel_scoreboard;
		logic [COORD_BITS-1:0] pen_x = '0;
		logic [COORD_BITS-1:0] pen_y = '0;
		logic                  seg_active = 1'b0;
		logic                  major_x = 1'b0;
		logic [COORD_BITS-1:0] major_pos = '0;
		logic [COORD_BITS-1:0] major_stop = '0;
		logic [ACC_W-1:0]      minor_acc = '0;
		logic [ACC_W:0]        minor_slope = '0;
		logic [23:0]           seg_color = '0;
		pix_beat_t             expected_pixels[$];
		int unsigned           error_count = 0;
		int unsigned           command_count = 0;

		// major axis pick, endpoint swap and slope division
		function void start_segment(logic [COORD_BITS-1:0] x0, y0, x1, y1);
			logic [COORD_BITS-1:0] dx, dy, a0, a1, b0, b1, len, mdelta;
			logic [ACC_W-1:0]      mag;
			logic                  neg;
			dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
			dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
			major_x = dx >= dy;
			if (major_x) begin
				a0 = x0; a1 = x1; b0 = y0; b1 = y1;
			end else begin
				a0 = y0; a1 = y1; b0 = x0; b1 = x1;
			end
			if (a1 < a0) begin
				{a0, a1} = {a1, a0};
				{b0, b1} = {b1, b0};
			end
			len = a1 - a0;
			major_pos = a0;
			major_stop = a1;
			minor_acc = {b0, {FRAC{1'b0}}};
			if (len == '0) begin
				minor_slope = '0;
				seg_active = 1'b0;
				return;
			end
			neg = b1 < b0;
			mdelta = neg ? b0 - b1 : b1 - b0;
			mag = {mdelta, {FRAC{1'b0}}} / len;
			minor_slope = {1'b0, mag};
			if (neg)
				minor_slope = -minor_slope;
			seg_active = 1'b1;
		endfunction

		function void note_command(cmd_beat_t c);
			pix_beat_t             px;
			logic [COORD_BITS:0]   next_pos;
			logic [COORD_BITS-1:0] minor;
			command_count++;
			case (c.opcode)
				OP_LINE: begin
					seg_color = {c.red, c.green, c.blue};
					start_segment(c.start_x, c.start_y, c.end_x, c.end_y);
				end
				OP_MOVETO: begin
					pen_x = c.end_x;
					pen_y = c.end_y;
				end
				OP_LINETO: begin
					seg_color = {c.red, c.green, c.blue};
					start_segment(pen_x, pen_y, c.end_x, c.end_y);
					pen_x = c.end_x;
					pen_y = c.end_y;
				end
				OP_STEP: begin
					// a step with no live segment is dropped
					if (seg_active) begin
						minor = minor_acc[ACC_W-1 -: COORD_BITS];
						next_pos = {1'b0, major_pos} + 1'b1;
						px.pixel_x = major_x ? major_pos : minor;
						px.pixel_y = major_x ? minor : major_pos;
						{px.pixel_red, px.pixel_green, px.pixel_blue} = seg_color;
						px.last_pixel = (next_pos[COORD_BITS-1:0] == major_stop) ||
							(next_pos >= {1'b0, major_stop});
						expected_pixels.push_back(px);
						major_pos = next_pos[COORD_BITS-1:0];
						minor_acc = minor_acc + minor_slope[ACC_W-1:0];
						if (px.last_pixel)
							seg_active = 1'b0;
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				error_count++;
			end
		endfunction

		function void check_pixel(pix_beat_t got);
			pix_beat_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel beat with none pending: x %0d y %0d", got.pixel_x, got.pixel_y);
				error_count++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
			compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
			compare_field("pixel_red", 32'(want.pixel_red), 32'(got.pixel_red));
			compare_field("pixel_green", 32'(want.pixel_green), 32'(got.pixel_green));
			compare_field("pixel_blue", 32'(want.pixel_blue), 32'(got.pixel_blue));
			compare_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	cmd_beat_t  cmd = '0;
	logic       pix_valid;
	logic       pix_ready = 1'b0;
	pix_beat_t  pix;

	pixel_scoreboard sb = new();
	cmd_beat_t       cmd_queue[$];
	int              gen_pen_x = 0;
	int              gen_pen_y = 0;
	int              live_items = 0;
	int              idle_cycles = 0;
	bit              hold_done = 1'b0;

	dda_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// reset held low from time zero, released once
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// command stream construction; tracks the pen so segment lengths are known
	function automatic void push_cmd(opcode_t op, int sx, int sy, int ex, int ey,
		logic [23:0] color);
		cmd_beat_t c;
		c.opcode = op;
		c.start_x = sx[COORD_BITS-1:0];
		c.start_y = sy[COORD_BITS-1:0];
		c.end_x = ex[COORD_BITS-1:0];
		c.end_y = ey[COORD_BITS-1:0];
		{c.red, c.green, c.blue} = color;
		if (op == OP_MOVETO || op == OP_LINETO) begin
			gen_pen_x = ex;
			gen_pen_y = ey;
		end
		cmd_queue.push_back(c);
		live_items++;
	endfunction

	function automatic int rand_coord();
		return $urandom_range(0, MAX_COORD);
	endfunction

	function automatic logic [23:0] rand_color();
		return 24'($urandom());
	endfunction

	function automatic void add_steps(int n);
		for (int i = 0; i < n; i++)
			push_cmd(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_color());
	endfunction

	// a point near base, reflected back inside the coordinate range
	function automatic int near_coord(int base, int span);
		int d, v;
		d = $urandom_range(0, 2 * span) - span;
		v = base + d;
		if (v < 0 || v > MAX_COORD)
			v = base - d;
		return v;
	endfunction

	function automatic int span_of(int x0, int y0, int x1, int y1);
		int dx, dy;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y1 - y0 : y0 - y1;
		return (dx > dy) ? dx : dy;
	endfunction

	// corners, octants, ties and the special cases
	function automatic void add_directed();
		push_cmd(OP_STEP, 0, 0, 0, 0, 24'h000000);          // nothing active yet
		push_cmd(OP_LINE, 10, 13, 12, 10, 24'hFFFFFF);      // steep, minor counts down
		add_steps(3);
		push_cmd(OP_LINE, MAX_COORD, MAX_COORD, MAX_COORD - 2, 0, rand_color());
		add_steps(2);                                      // longest segment, abandoned
		push_cmd(OP_LINE, 0, MAX_COORD, MAX_COORD, 0, rand_color()); // tie goes to x
		add_steps(2);
		push_cmd(OP_LINE, 7, 7, 7, 7, rand_color());        // zero length
		add_steps(1);
		push_cmd(OP_MOVETO, 0, 0, MAX_COORD, 0, rand_color());
		push_cmd(OP_LINETO, 0, 0, MAX_COORD - 3, 1, rand_color()); // swapped ends
		add_steps(1);
		push_cmd(OP_MOVETO, 0, 0, 0, MAX_COORD, rand_color()); // segment keeps running
		add_steps(2);
		push_cmd(OP_LINETO, MAX_COORD, MAX_COORD, 0, MAX_COORD, rand_color()); // zero length
		add_steps(1);
		push_cmd(OP_LINETO, 0, 0, MAX_COORD, MAX_COORD, rand_color());
		add_steps(1);
	endfunction

	// well-formed segment with random content, sometimes cut short or interleaved
	function automatic void add_segment();
		int sx, sy, ex, ey, span, len, live, mid, extra;
		span = ($urandom_range(0, 7) == 0) ? 60 : 12;
		if ($urandom_range(0, 3) == 0)
			push_cmd(OP_MOVETO, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_color());
		if ($urandom_range(0, 1) == 0) begin
			sx = rand_coord();
			sy = rand_coord();
			ex = near_coord(sx, span);
			ey = near_coord(sy, span);
			push_cmd(OP_LINE, sx, sy, ex, ey, rand_color());
		end else begin
			sx = gen_pen_x;
			sy = gen_pen_y;
			ex = near_coord(sx, span);
			ey = near_coord(sy, span);
			push_cmd(OP_LINETO, rand_coord(), rand_coord(), ex, ey, rand_color());
		end
		len = span_of(sx, sy, ex, ey);
		live = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len) : len;
		mid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, live) : -1;
		for (int i = 0; i < live; i++) begin
			if (i == mid)
				push_cmd(OP_MOVETO, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_color());
			add_steps(1);
		end
		// steps past the end are dropped by the block
		if (live == len && $urandom_range(0, 3) == 0) begin
			extra = $urandom_range(1, 2);
			add_steps(extra);
			live_items -= extra;
		end
	endfunction

	function automatic void add_random();
		int kind, p;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			add_segment();
		end else if (kind == 7) begin
			// zero-length draw, then a step that must produce nothing
			if ($urandom_range(0, 1) == 0) begin
				push_cmd(OP_LINETO, rand_coord(), rand_coord(), gen_pen_x, gen_pen_y,
					rand_color());
			end else begin
				p = rand_coord();
				push_cmd(OP_LINE, p, gen_pen_y, p, gen_pen_y, rand_color());
			end
			add_steps(1);
			live_items--;
		end else begin
			// noise: any opcode, any fields, a few steps on whatever is live
			push_cmd(opcode_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_color());
			add_steps($urandom_range(0, 4));
		end
	endfunction

	// beat monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				sb.note_command(cmd);
			if (pix_valid && pix_ready)
				sb.check_pixel(pix);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// pixel receiver: stall patterns, plus one long hold-off to back up the command side
	initial begin
		int mode, run, phase;
		phase = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && sb.command_count >= 150) begin
				hold_done = 1'b1;
				pix_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run = $urandom_range(5, 80);
			repeat (run) begin
				case (mode)
					0: pix_ready <= 1'b1;
					1: pix_ready <= ($urandom_range(0, 9) < 7);
					2: pix_ready <= (phase % 4 != 0);
					default: pix_ready <= ($urandom_range(0, 9) < 3);
				endcase
				@(posedge clk);
				phase++;
			end
		end
	end

	// command sender in bursts, then drain and verdict
	initial begin
		int burst, gap;
		add_directed();
		live_items = 0;
		while (live_items < RANDOM_ITEMS)
			add_random();
		wait (arst_n === 1'b1);
		@(posedge clk);
		while (cmd_queue.size() != 0) begin
			burst = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			while (burst > 0 && cmd_queue.size() != 0) begin
				cmd_valid <= 1'b1;
				cmd <= cmd_queue.pop_front();
				do @(posedge clk); while (!cmd_ready);
				burst--;
			end
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0 && sb.expected_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
